@@ hw/rtl/gcdlcm_pkg.sv @@
package gcdlcm_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int IN_WIDTH          = 32;
  localparam int RESULT_WIDTH      = 64;

  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

endpackage

@@ hw/rtl/gcdlcm_div.sv @@
module gcdlcm_div #(
  parameter int W = gcdlcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;

  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             ge;
  logic [W-1:0]     rem_nxt;
  logic [W-1:0]     quo_nxt;

  // One restoring step per cycle: shift in the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    rem_sh  = {rem_r, quo_r[W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = !diff[W];
    rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(W - 1);
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ hw/rtl/gcd_lcm_unit.sv @@
// Channel   Transfer condition     Ports
// input     start && !busy         in_op, in_operand_a, in_operand_b
// result    out_valid (1 cycle)    out_result
//
// Each Euclidean step is one pass through the sequencing state plus one divider run,
// and the LCM adds one division and one multiply state after the GCD is found.
// Reset is synchronous and active low; busy is high from the transfer until the
// result cycle. The receiver cannot stall: the result is shown for one cycle.
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [gcdlcm_pkg::IN_WIDTH-1:0]     in_operand_a,
  input  logic [gcdlcm_pkg::IN_WIDTH-1:0]     in_operand_b,
  output logic                                out_valid,
  output logic [gcdlcm_pkg::RESULT_WIDTH-1:0] out_result
);

  import gcdlcm_pkg::*;

  localparam int W      = OPERAND_WIDTH;
  localparam int PROD_W = 2 * OPERAND_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_MOD,
    S_QUO,
    S_MUL
  } state_t;

  state_t                  state_r;
  logic                    op_r;
  logic [W-1:0]            a_r;
  logic [W-1:0]            b_r;
  logic [W-1:0]            orig_a_r;
  logic [W-1:0]            orig_b_r;
  logic                    out_valid_r;
  logic [RESULT_WIDTH-1:0] out_result_r;

  logic                    gcd_found;
  logic                    lcm_zero;
  logic                    div_start;
  logic [W-1:0]            div_dividend;
  logic [W-1:0]            div_divisor;
  logic                    div_done;
  logic [W-1:0]            div_quo;
  logic [W-1:0]            div_rem;
  logic [PROD_W-1:0]       product;

  always_comb begin
    gcd_found    = (b_r == '0);
    lcm_zero     = (orig_a_r == '0) || (orig_b_r == '0);
    div_start    = (state_r == S_LOOP) && (!gcd_found || (op_r == OP_LCM && !lcm_zero));
    div_dividend = gcd_found ? orig_a_r : a_r;
    div_divisor  = gcd_found ? a_r : b_r;
    product      = PROD_W'(div_quo) * PROD_W'(orig_b_r);
  end

  gcdlcm_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_op;
            a_r      <= in_operand_a[W-1:0];
            b_r      <= in_operand_b[W-1:0];
            orig_a_r <= in_operand_a[W-1:0];
            orig_b_r <= in_operand_b[W-1:0];
            state_r  <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (!gcd_found) begin
            state_r <= S_MOD;
          end else if (op_r == OP_GCD) begin
            out_result_r <= RESULT_WIDTH'(a_r);
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else if (lcm_zero) begin
            out_result_r <= '0;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_QUO;
          end
        end
        S_MOD: begin
          if (div_done) begin
            a_r     <= b_r;
            b_r     <= div_rem;
            state_r <= S_LOOP;
          end
        end
        S_QUO: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          out_result_r <= RESULT_WIDTH'(product);
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the sequencer is still busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start the sequencer");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_MOD || state_r == S_QUO))
    else $error("divider finished while the sequencer was not waiting");

endmodule

@@ test/gcd_lcm_checker.sv @@
`timescale 1ns / 100ps

module gcd_lcm_checker #(
  parameter int OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                in_op,
  input  logic [gcdlcm_pkg::IN_WIDTH-1:0]     in_operand_a,
  input  logic [gcdlcm_pkg::IN_WIDTH-1:0]     in_operand_b,
  input  logic                                out_valid,
  input  logic [gcdlcm_pkg::RESULT_WIDTH-1:0] out_result,
  output int                                  mismatches,
  output int                                  pending_results
);

  import gcdlcm_pkg::*;

  typedef struct {
    logic                    op;
    logic [IN_WIDTH-1:0]     a;
    logic [IN_WIDTH-1:0]     b;
    logic [RESULT_WIDTH-1:0] result;
  } gcd_lcm_job_t;

  localparam logic [RESULT_WIDTH-1:0] OPERAND_MASK =
    (RESULT_WIDTH'(1) << OPERAND_WIDTH) - RESULT_WIDTH'(1);

  gcd_lcm_job_t awaited_results[$];
  int           fail_count    = 0;
  int           awaited_count = 0;

  assign mismatches      = fail_count;
  assign pending_results = awaited_count;

  function automatic logic [RESULT_WIDTH-1:0] predict_gcd_lcm(
    input logic                op,
    input logic [IN_WIDTH-1:0] a_in,
    input logic [IN_WIDTH-1:0] b_in
  );
    logic [RESULT_WIDTH-1:0] a;
    logic [RESULT_WIDTH-1:0] b;
    logic [RESULT_WIDTH-1:0] x;
    logic [RESULT_WIDTH-1:0] y;
    logic [RESULT_WIDTH-1:0] rem;
    a = RESULT_WIDTH'(a_in) & OPERAND_MASK;
    b = RESULT_WIDTH'(b_in) & OPERAND_MASK;
    x = a;
    y = b;
    while (y != '0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    if (op == OP_GCD) begin
      return x;
    end
    // A zero operand makes the least common multiple zero by definition.
    if (a == '0 || b == '0) begin
      return '0;
    end
    return (a / x) * b;
  endfunction

  always @(posedge clk) begin : watch_channels
    gcd_lcm_job_t job;
    if (rst_n) begin
      if (start && !busy) begin
        job.op     = in_op;
        job.a      = in_operand_a;
        job.b      = in_operand_b;
        job.result = predict_gcd_lcm(in_op, in_operand_a, in_operand_b);
        awaited_results.push_back(job);
      end
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with none expected: expected nothing, actual %0d",
                   $time, out_result);
          fail_count++;
        end else begin
          job = awaited_results.pop_front();
          if (out_result !== job.result) begin
            $display("%0t: op %0d a %0d b %0d: result expected %0d, actual %0d",
                     $time, job.op, job.a, job.b, job.result, out_result);
            fail_count++;
          end
        end
      end
      awaited_count <= awaited_results.size();
    end
  end

endmodule

@@ test/gcd_lcm_unit_tb.sv @@
`timescale 1ns / 100ps

module gcd_lcm_unit_tb;

  import gcdlcm_pkg::*;

  localparam int     RANDOM_TRANSFERS = 1400;
  localparam int     CALM_TAIL        = 150;
  localparam int     DRAIN_CYCLES     = 2200;
  localparam longint CYCLE_LIMIT      = 10_000_000;

  localparam logic [IN_WIDTH-1:0] ALL_ONES = '1;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    start        = 1'b0;
  logic                    in_op        = OP_GCD;
  logic [IN_WIDTH-1:0]     in_operand_a = '0;
  logic [IN_WIDTH-1:0]     in_operand_b = '0;
  logic                    busy;
  logic                    out_valid;
  logic [RESULT_WIDTH-1:0] out_result;
  int                      mismatches;
  int                      pending_results;
  longint                  cycle_count  = 0;
  bit                      idling_on    = 1'b1;

  gcd_lcm_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_result   (out_result)
  );

  gcd_lcm_checker result_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gcd_lcm_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic send_transfer(
    input logic                op,
    input logic [IN_WIDTH-1:0] a,
    input logic [IN_WIDTH-1:0] b
  );
    start        <= 1'b1;
    in_op        <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (busy);
    if (idling_on) begin
      case ($urandom_range(0, 2))
        0: begin
        end
        1: begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        default: begin
          start <= 1'b0;
          do @(posedge clk); while (busy);
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      endcase
    end
  endtask

  task automatic pick_operands(
    output logic [IN_WIDTH-1:0] a,
    output logic [IN_WIDTH-1:0] b
  );
    logic [IN_WIDTH-1:0] factor;
    logic [IN_WIDTH-1:0] fib_lo;
    logic [IN_WIDTH-1:0] fib_hi;
    logic [IN_WIDTH-1:0] fib_next;
    int                  steps;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3, 4: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      5, 6: begin
        factor = $urandom_range(1, 65535);
        a      = factor * $urandom_range(0, 65535);
        b      = factor * $urandom_range(0, 65535);
      end
      7: begin
        a = (IN_WIDTH'(1) << $urandom_range(0, 31)) * $urandom_range(1, 7);
        b = IN_WIDTH'(1) << $urandom_range(0, 31);
      end
      8: begin
        // Consecutive Fibonacci numbers give the longest Euclidean chains.
        steps  = $urandom_range(1, 45);
        fib_lo = 1;
        fib_hi = 1;
        repeat (steps) begin
          fib_next = fib_lo + fib_hi;
          fib_lo   = fib_hi;
          fib_hi   = fib_next;
        end
        if ($urandom_range(0, 1)) begin
          a = fib_hi;
          b = fib_lo;
        end else begin
          a = fib_lo;
          b = fib_hi;
        end
      end
      default: begin
        case ($urandom_range(0, 3))
          0: a = '0;
          1: a = 1;
          2: a = ALL_ONES;
          default: a = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0: b = '0;
          1: b = 1;
          2: b = ALL_ONES;
          default: b = $urandom;
        endcase
      end
    endcase
  endtask

  initial begin
    logic [IN_WIDTH-1:0] a;
    logic [IN_WIDTH-1:0] b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_transfer(OP_GCD, 0, 0);
    send_transfer(OP_LCM, 0, 0);
    send_transfer(OP_GCD, 0, ALL_ONES);
    send_transfer(OP_GCD, ALL_ONES, 0);
    send_transfer(OP_LCM, 0, 12345);
    send_transfer(OP_LCM, 987654, 0);
    send_transfer(OP_GCD, ALL_ONES, ALL_ONES);
    send_transfer(OP_LCM, ALL_ONES, ALL_ONES);
    send_transfer(OP_LCM, ALL_ONES, ALL_ONES - 1);
    send_transfer(OP_GCD, 1, ALL_ONES);
    send_transfer(OP_LCM, ALL_ONES, 1);
    send_transfer(OP_GCD, 32'd2971215073, 32'd1836311903);
    send_transfer(OP_LCM, 32'd2971215073, 32'd1836311903);
    send_transfer(OP_GCD, 32'd4294967291, 32'd4294967279);
    send_transfer(OP_LCM, 32'd4294967291, 32'd4294967279);
    send_transfer(OP_GCD, 32'h8000_0000, 32'h0001_0000);
    send_transfer(OP_LCM, 32'hAAAA_AAAA, 32'h5555_5555);
    send_transfer(OP_GCD, 32'h5555_5555, 32'hAAAA_AAAA);
    send_transfer(OP_GCD, 1000000, 75000);
    send_transfer(OP_LCM, 36, 48);
    send_transfer(OP_GCD, 12, 12);

    for (int i = 0; i < RANDOM_TRANSFERS; i++) begin
      if (i == RANDOM_TRANSFERS - CALM_TAIL) begin
        idling_on = 1'b0;
      end
      pick_operands(a, b);
      send_transfer($urandom_range(0, 1) ? OP_LCM : OP_GCD, a, b);
    end
    start <= 1'b0;

    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results == 0) begin
      $display("gcd_lcm_unit_tb: PASS");
    end else begin
      $display("gcd_lcm_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
